// ===== design/sfm_pkg.sv =====
package sfm_pkg;

  typedef enum logic {
    ACT_PATTERN = 1'b0,
    ACT_TEXT    = 1'b1
  } action_e;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 16;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic             step;
    logic             clear;
    logic [ByteW-1:0] text_byte;
  } cell_ctrl_t;

  typedef struct packed {
    logic [PosW-1:0] match_position;
    logic            pattern_too_long;
  } result_t;

endpackage

// ===== design/substring_first_match.sv =====
// Channel  Dir  tdata                  tuser               tlast
// s_axis   in   [7:0] byte_value       action (0 pat/1 txt) is_last
// m_axis   out  [15:0] match_position  pattern_too_long    -
//
// One request is taken per cycle, pattern and text alike; each cell of the
// chain compares its pattern byte with the text byte in that same cycle.
// A result is pushed when the last text byte is taken and waits in a
// two-entry output buffer, so input stalls only when both entries are held.
// Reset clears all control state and the match bits; pattern bytes are not
// cleared and only written positions are ever used.
module substring_first_match #(
  parameter int unsigned MAX_PATTERN    = 32,
  parameter int unsigned POSITION_LIMIT = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] match_position
  output logic        m_axis_tuser    // [0] pattern_too_long
);
  import sfm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CntW = $clog2(POSITION_LIMIT + MAX_PATTERN + 1);
  localparam int unsigned FndW = $clog2(POSITION_LIMIT + 1);
  localparam logic [CntW-1:0] CntCap  = CntW'(POSITION_LIMIT + MAX_PATTERN);
  localparam logic [CntW-1:0] PosLim  = CntW'(POSITION_LIMIT);
  localparam logic [LenW-1:0] LenMax  = LenW'(MAX_PATTERN);

  logic [LenW-1:0] len_q, len_d;
  logic            closed_q, closed_d;
  logic            overflow_q, overflow_d;
  logic [CntW-1:0] count_q, count_d;
  logic [FndW-1:0] found_q, found_d;

  logic            accept;
  logic            is_text;
  logic [LenW-1:0] len_eff;
  logic            ovf_eff;
  logic            space;
  logic            push;
  result_t         push_data;
  cell_ctrl_t      ctrl;

  logic [MAX_PATTERN-1:0] load_en;
  logic [MAX_PATTERN:0]   chain;
  logic [MAX_PATTERN-1:0] bit_next;
  logic [IdxW-1:0]        tail_idx;
  logic [CntW-1:0]        count_inc;
  logic [CntW-1:0]        len_ext;
  logic [CntW-1:0]        diff;
  logic                   hit;
  logic [FndW-1:0]        found_new;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;
  assign is_text       = (action_e'(s_axis_tuser) == ACT_TEXT);

  // A pattern byte after a closed pattern restarts the pattern.
  assign len_eff = closed_q ? '0 : len_q;
  assign ovf_eff = closed_q ? 1'b0 : overflow_q;

  assign ctrl.text_byte = s_axis_tdata;
  assign ctrl.step      = accept && is_text && (len_q != '0) && !overflow_q;
  assign ctrl.clear     = accept && (!is_text || s_axis_tlast);

  assign chain[0] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign load_en[k] = accept && !is_text && (len_eff == LenW'(k));
    sfm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_en_i   (load_en[k]),
      .load_byte_i (s_axis_tdata),
      .prev_bit_i  (chain[k]),
      .bit_o       (chain[k+1]),
      .bit_next_o  (bit_next[k])
    );
  end

  assign tail_idx  = IdxW'(len_q - LenW'(1));
  assign count_inc = (count_q < CntCap) ? count_q + CntW'(1) : count_q;
  assign len_ext   = CntW'(len_q);
  assign diff      = count_inc - len_ext;
  // The start position is diff + 1; it must not pass the position limit.
  assign hit       = ctrl.step && bit_next[tail_idx] && (found_q == '0) &&
                     (count_inc >= len_ext) && (diff < PosLim);
  assign found_new = hit ? FndW'(diff + CntW'(1)) : found_q;

  always_comb begin
    len_d      = len_q;
    closed_d   = closed_q;
    overflow_d = overflow_q;
    count_d    = count_q;
    found_d    = found_q;
    if (accept) begin
      if (!is_text) begin
        count_d = '0;
        found_d = '0;
        if (len_eff < LenMax) begin
          len_d      = len_eff + LenW'(1);
          overflow_d = ovf_eff;
        end else begin
          len_d      = len_eff;
          overflow_d = 1'b1;
        end
        closed_d = s_axis_tlast;
      end else begin
        closed_d = 1'b1;
        if (s_axis_tlast) begin
          count_d = '0;
          found_d = '0;
        end else begin
          count_d = count_inc;
          found_d = found_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      closed_q   <= 1'b0;
      overflow_q <= 1'b0;
      count_q    <= '0;
      found_q    <= '0;
    end else begin
      len_q      <= len_d;
      closed_q   <= closed_d;
      overflow_q <= overflow_d;
      count_q    <= count_d;
      found_q    <= found_d;
    end
  end

  assign push = accept && is_text && s_axis_tlast;
  assign push_data.match_position   = overflow_q ? '0 : PosW'(found_new);
  assign push_data.pattern_too_long = overflow_q;

  result_t out_data;

  sfm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_data)
  );

  assign m_axis_tdata = out_data.match_position;
  assign m_axis_tuser = out_data.pattern_too_long;

  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LenMax)
    else $error("pattern length beyond the store");
  assert property (@(posedge clk_i) disable iff (!rst_ni) overflow_q |-> len_q == LenMax)
    else $error("overflow flagged with a store that is not full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q != '0) |-> (CntW'(found_q) <= count_q) && (CntW'(found_q) <= PosLim))
    else $error("recorded match start outside the text seen");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("overlong pattern reported with a match position");

endmodule

// ===== design/sfm_cell.sv =====
module sfm_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfm_pkg::cell_ctrl_t    ctrl_i,
  input  logic                   load_en_i,
  input  logic [7:0]             load_byte_i,
  input  logic                   prev_bit_i,
  output logic                   bit_o,
  output logic                   bit_next_o
);
  import sfm_pkg::*;

  logic [ByteW-1:0] pat_byte_q;
  logic             bit_q;
  logic             bit_d;
  logic             cmp_hit;

  // Step value of this offset, seen even when the search state is cleared
  // in the same cycle so that the final text byte can still complete a match.
  assign cmp_hit = prev_bit_i && (pat_byte_q == ctrl_i.text_byte);

  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctrl_i.step) begin
      bit_d = cmp_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      pat_byte_q <= load_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o      = bit_q;
  assign bit_next_o = cmp_hit;

endmodule

// ===== design/sfm_out_buf.sv =====
module sfm_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfm_pkg::result_t    push_data_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output sfm_pkg::result_t    data_o
);
  import sfm_pkg::*;

  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    pop;

  assign pop     = out_valid_q && ready_i;
  assign space_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // The skid stage is only filled while the output stage holds a stalled request.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output stage empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !ready_i) |=> skid_valid_q && out_valid_q)
    else $error("stalled result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o && $stable(data_o))
    else $error("stalled result changed");

endmodule
